[hdl/salc_pkg.sv]
// Package for the set-associative LRU cache lookup block.
// Holds the sizes, the queue word and metadata types, and register indexes.
// No dependencies.
package salc_pkg;

  localparam int MAX_WAYS      = 4;
  localparam int MAX_SET_BITS  = 12;
  localparam int ADDRESS_BITS  = 48;
  localparam int LINE_BITS_MIN = 2;
  localparam int LINE_BITS_MAX = 8;

  localparam int LINE_W    = ADDRESS_BITS - LINE_BITS_MIN;
  localparam int SET_W     = MAX_SET_BITS;
  localparam int SET_DEPTH = 1 << MAX_SET_BITS;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TAG_ROW_W = MAX_WAYS * LINE_W;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_BITS = 2'd0,
    CFG_SET_BITS  = 2'd1,
    CFG_WAY_COUNT = 2'd2
  } cfg_idx_t;

  // One classified reference on its way from the front to the back.
  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [SET_W-1:0]  set;
    logic [2:0]        way_count;
    logic              is_write;
  } job_t;

  // Per-set metadata: valid and dirty bits per way, and LRU order
  // (position 0 is most recent).
  typedef struct packed {
    logic [MAX_WAYS-1:0]            valid;
    logic [MAX_WAYS-1:0]            dirty;
    logic [MAX_WAYS-1:0][WAY_W-1:0] ord;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  function automatic meta_t meta_reset();
    meta_t m;
    m.valid = '0;
    m.dirty = '0;
    for (int p = 0; p < MAX_WAYS; p++) m.ord[p] = WAY_W'(p);
    return m;
  endfunction

endpackage

[hdl/salc_in_if.sv]
// Input channel: one memory reference word with valid/ready.
// Depends on salc_pkg.
interface salc_in_if;
  import salc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ADDRESS_BITS-1:0] address;
  logic                    is_write;
  modport source (output valid, address, is_write, input ready);
  modport sink   (input valid, address, is_write, output ready);
endinterface

[hdl/salc_out_if.sv]
// Result channel: one lookup result word with valid/ready.
// Depends on salc_pkg.
interface salc_out_if;
  import salc_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [1:0]       way_used;
  logic             dirty_evicted;
  logic [CNT_W-1:0] reference_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] eviction_total;
  logic [CNT_W-1:0] update_total;
  modport source (output valid, hit, way_used, dirty_evicted, reference_total, miss_total,
                  eviction_total, update_total, input ready);
  modport sink   (input valid, hit, way_used, dirty_evicted, reference_total, miss_total,
                  eviction_total, update_total, output ready);
endinterface

[hdl/set_assoc_lru_cache_lookup.sv]
// Top level of the set-associative write-back cache lookup with true LRU.
// Depends on salc_pkg, salc_in_if, salc_out_if, salc_front and salc_back.
//
//   Channel  | Direction | Word
//   in_ch    | in        | address, is_write
//   out_ch   | out       | hit, way_used, dirty_evicted, four running totals
//   cfg_*    | in        | write enable, register index, 4-bit data
//
// Each word passes through the back end in order: ST_IDLE reads the set's
// tag row and metadata from single-port RAM, then ST_CMP compares, updates
// and writes back. After reset the back end sweeps all 4096 sets of the
// metadata RAM, one set per cycle; no input word is accepted during that
// sweep. A two-word queue keeps the input open while a result waits on a
// stalled output, and the result register holds its word until it is taken.
module set_assoc_lru_cache_lookup (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [salc_pkg::CFG_DAT_W-1:0] cfg_data,
  salc_in_if.sink                        in_ch,
  salc_out_if.source                     out_ch
);
  import salc_pkg::*;

  logic ready_for_work;
  logic job_valid, job_ready;
  job_t job;

  // The front end classifies each word into line and set with the
  // clamped register values and queues it.
  salc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .enable(ready_for_work), .in_ch(in_ch),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  // The back end owns the stores and the counters.
  salc_back u_back (
    .clk(clk), .rst_n(rst_n), .ready_for_work(ready_for_work),
    .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .out_ch(out_ch)
  );
endmodule

[hdl/salc_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[addr] <= wdata;
    if (re) rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;
endmodule

[hdl/salc_front.sv]
// Front end: configuration registers, address classification and a
// two-word queue toward the back end. Depends on salc_pkg and salc_in_if.
module salc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [salc_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                          enable,
  salc_in_if.sink                       in_ch,
  output logic                          job_valid,
  input  logic                          job_ready,
  output salc_pkg::job_t                job
);
  import salc_pkg::*;

  logic [3:0] line_bits_r;
  logic [3:0] set_bits_r;
  logic [2:0] way_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bits_r <= 4'd6;
      set_bits_r  <= 4'd12;
      way_count_r <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_BITS: line_bits_r <= cfg_data[3:0];
        CFG_SET_BITS:  set_bits_r  <= cfg_data[3:0];
        CFG_WAY_COUNT: way_count_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to their meaningful ranges.
  logic [3:0]  lb, sb;
  logic [2:0]  wc;
  logic [SET_W-1:0] set_mask;
  job_t        job_in;

  always_comb begin
    lb = line_bits_r;
    if (lb < 4'(LINE_BITS_MIN)) lb = 4'(LINE_BITS_MIN);
    if (lb > 4'(LINE_BITS_MAX)) lb = 4'(LINE_BITS_MAX);
    sb = set_bits_r;
    if (sb > 4'(MAX_SET_BITS)) sb = 4'(MAX_SET_BITS);
    wc = way_count_r;
    if (wc < 3'd1) wc = 3'd1;
    if (wc > 3'(MAX_WAYS)) wc = 3'(MAX_WAYS);
    set_mask         = ~({SET_W{1'b1}} << sb);
    job_in.line      = LINE_W'(in_ch.address >> lb);
    job_in.set       = job_in.line[SET_W-1:0] & set_mask;
    job_in.way_count = wc;
    job_in.is_write  = in_ch.is_write;
  end

  // Two-entry queue.
  job_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ch.ready = enable && (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign job_valid   = (cnt_r != 2'd0);
  assign pop         = job_valid && job_ready;
  assign job         = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= job_in;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

[hdl/salc_back.sv]
// Back end: clears the metadata after reset, then looks up, updates the
// tag and metadata RAMs and the counters, and holds the result word.
// Depends on salc_pkg, salc_out_if and salc_ram.
module salc_back (
  input  logic           clk,
  input  logic           rst_n,
  output logic           ready_for_work,
  input  logic           job_valid,
  output logic           job_ready,
  input  salc_pkg::job_t job,
  salc_out_if.source     out_ch
);
  import salc_pkg::*;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_CMP} state_t;

  state_t           state_r;
  logic [SET_W-1:0] clr_r;
  job_t             job_r;
  logic [CNT_W-1:0] ref_r, miss_r, evc_r, upd_r;
  logic             out_valid_r, hit_r, evict_r;
  logic [1:0]       way_r;

  // RAM ports
  logic             ram_we, ram_re;
  logic [SET_W-1:0] ram_addr;
  meta_t            meta_wd, meta_rd;
  logic [TAG_ROW_W-1:0] tag_wd, tag_rd;
  logic             tag_we;

  salc_ram #(.WIDTH(META_W), .DEPTH(SET_DEPTH)) u_meta (
    .clk(clk), .we(ram_we), .re(ram_re), .addr(ram_addr), .wdata(meta_wd), .rdata(meta_rd)
  );
  salc_ram #(.WIDTH(TAG_ROW_W), .DEPTH(SET_DEPTH)) u_tag (
    .clk(clk), .we(tag_we), .re(ram_re), .addr(ram_addr), .wdata(tag_wd), .rdata(tag_rd)
  );

  // Lookup and update of the set read in state ST_IDLE.
  logic [MAX_WAYS-1:0] way_hit;
  logic                hit;
  logic [WAY_W-1:0]    found, way;
  logic                evict;
  meta_t               meta_nx;
  logic                can_emit;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_hit[w] = meta_rd.valid[w] && (tag_rd[w*LINE_W +: LINE_W] == job_r.line);
    end
    hit   = 1'b0;
    found = '0;
    way   = '0;
    for (int p = MAX_WAYS - 1; p >= 0; p--) begin
      if ((3'(p) < job_r.way_count) && way_hit[meta_rd.ord[p]]) begin
        hit   = 1'b1;
        found = WAY_W'(p);
        way   = meta_rd.ord[p];
      end
    end
    if (!hit) begin
      found = WAY_W'(job_r.way_count - 3'd1);
      way   = meta_rd.ord[found];
    end
    evict = !hit && meta_rd.valid[way] && meta_rd.dirty[way];

    meta_nx = meta_rd;
    meta_nx.valid[way] = 1'b1;
    if (!hit) meta_nx.dirty[way] = 1'b0;
    if (job_r.is_write) meta_nx.dirty[way] = 1'b1;
    for (int p = 1; p < MAX_WAYS; p++) begin
      if (WAY_W'(p) <= found) meta_nx.ord[p] = meta_rd.ord[p-1];
    end
    meta_nx.ord[0] = way;

    tag_wd = tag_rd;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) == way) tag_wd[w*LINE_W +: LINE_W] = job_r.line;
    end
  end

  assign can_emit  = !out_valid_r || out_ch.ready;
  assign job_ready = (state_r == ST_IDLE);
  assign ready_for_work = (state_r != ST_CLEAR);

  always_comb begin
    ram_we   = 1'b0;
    tag_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = job_r.set;
    meta_wd  = meta_nx;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_r;
        meta_wd  = meta_reset();
      end
      ST_IDLE: begin
        ram_re   = job_valid;
        ram_addr = job.set;
      end
      ST_CMP: begin
        ram_we = can_emit;
        tag_we = can_emit && !hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      ref_r       <= '0;
      miss_r      <= '0;
      evc_r       <= '0;
      upd_r       <= '0;
    end else begin
      // A new result loads the output register; otherwise a taken word clears it.
      if ((state_r == ST_CMP) && can_emit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + SET_W'(1);
          if (clr_r == {SET_W{1'b1}}) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (job_valid) begin
            job_r   <= job;
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (can_emit) begin
            hit_r       <= hit;
            way_r       <= 2'(way);
            evict_r     <= evict;
            ref_r       <= ref_r + CNT_W'(1);
            miss_r      <= miss_r + CNT_W'(!hit);
            evc_r       <= evc_r + CNT_W'(evict);
            upd_r       <= upd_r + CNT_W'(job_r.is_write);
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.hit             = hit_r;
  assign out_ch.way_used        = way_r;
  assign out_ch.dirty_evicted   = evict_r;
  assign out_ch.reference_total = ref_r;
  assign out_ch.miss_total      = miss_r;
  assign out_ch.eviction_total  = evc_r;
  assign out_ch.update_total    = upd_r;
endmodule

[dv/salc_lookup_checker.sv]
// Checker for the set-associative LRU cache lookup: watches the config port and both
// channels, predicts each result word and compares it. Depends on salc_pkg,
// salc_in_if and salc_out_if.
module salc_lookup_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [salc_pkg::CFG_DAT_W-1:0] cfg_data,
  salc_in_if                             in_mon,
  salc_out_if                            out_mon,
  output int                             fail_count,
  output int                             pending
);
  import salc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit        hit;
    bit [1:0]  way_used;
    bit        dirty_evicted;
    bit [31:0] refs;
    bit [31:0] misses;
    bit [31:0] evictions;
    bit [31:0] updates;
  } lookup_word_t;

  bit [LINE_W-1:0] line_tag [SET_DEPTH][MAX_WAYS];
  bit              line_valid [SET_DEPTH][MAX_WAYS];
  bit              line_dirty [SET_DEPTH][MAX_WAYS];
  bit [1:0]        recency [SET_DEPTH][MAX_WAYS];
  bit [31:0]       n_refs, n_misses, n_evictions, n_updates;
  bit [3:0]        line_bits_reg, set_bits_reg;
  bit [2:0]        way_count_reg;
  lookup_word_t    lookups_due[$];

  function automatic lookup_word_t lookup_line(bit [ADDRESS_BITS-1:0] addr, bit wr);
    lookup_word_t    r;
    int              lb, sb, wc, found, set_idx;
    bit [LINE_W-1:0] line;
    bit [1:0]        way;
    lb = line_bits_reg;
    sb = set_bits_reg;
    wc = way_count_reg;
    if (lb < LINE_BITS_MIN) lb = LINE_BITS_MIN;
    if (lb > LINE_BITS_MAX) lb = LINE_BITS_MAX;
    if (sb > MAX_SET_BITS) sb = MAX_SET_BITS;
    if (wc < 1) wc = 1;
    if (wc > MAX_WAYS) wc = MAX_WAYS;
    line = LINE_W'(addr >> lb);
    set_idx = int'(line & ((64'd1 << sb) - 1));
    r = '{default: 0};
    found = 0;
    way = 0;
    n_refs++;
    for (int p = 0; p < wc; p++) begin
      if (!r.hit && line_valid[set_idx][recency[set_idx][p]] &&
          line_tag[set_idx][recency[set_idx][p]] == line) begin
        r.hit = 1;
        way = recency[set_idx][p];
        found = p;
      end
    end
    if (!r.hit) begin
      found = wc - 1;
      way = recency[set_idx][found];
      n_misses++;
      if (line_valid[set_idx][way] && line_dirty[set_idx][way]) begin
        n_evictions++;
        r.dirty_evicted = 1;
      end
      line_dirty[set_idx][way] = 0;
      line_valid[set_idx][way] = 1;
      line_tag[set_idx][way] = line;
    end
    for (int p = found; p > 0; p--) recency[set_idx][p] = recency[set_idx][p-1];
    recency[set_idx][0] = way;
    if (wr) begin
      line_dirty[set_idx][way] = 1;
      n_updates++;
    end
    r.way_used = way;
    r.refs = n_refs;
    r.misses = n_misses;
    r.evictions = n_evictions;
    r.updates = n_updates;
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_word_t e;
    if (!rst_n) begin
      for (int s = 0; s < SET_DEPTH; s++)
        for (int w = 0; w < MAX_WAYS; w++) begin
          line_valid[s][w] = 0;
          line_dirty[s][w] = 0;
          recency[s][w] = 2'(w);
        end
      {n_refs, n_misses, n_evictions, n_updates} = '0;
      line_bits_reg = 4'd6;
      set_bits_reg = 4'd12;
      way_count_reg = 3'd4;
      lookups_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LINE_BITS: line_bits_reg = cfg_data;
          CFG_SET_BITS:  set_bits_reg = cfg_data;
          CFG_WAY_COUNT: way_count_reg = cfg_data[2:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        lookups_due.push_back(lookup_line(in_mon.address, in_mon.is_write));
      if (out_mon.valid && out_mon.ready) begin
        if (lookups_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: result word with nothing expected", $realtime);
        end else begin
          e = lookups_due.pop_front();
          if (out_mon.hit !== e.hit || out_mon.way_used !== e.way_used ||
              out_mon.dirty_evicted !== e.dirty_evicted ||
              out_mon.reference_total !== e.refs || out_mon.miss_total !== e.misses ||
              out_mon.eviction_total !== e.evictions || out_mon.update_total !== e.updates) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp hit=%0d way=%0d ev=%0d tot=%0d/%0d/%0d/%0d got hit=%0d way=%0d ev=%0d tot=%0d/%0d/%0d/%0d",
                       $realtime, e.hit, e.way_used, e.dirty_evicted, e.refs, e.misses,
                       e.evictions, e.updates, out_mon.hit, out_mon.way_used,
                       out_mon.dirty_evicted, out_mon.reference_total, out_mon.miss_total,
                       out_mon.eviction_total, out_mon.update_total);
          end
        end
      end
    end
    pending = lookups_due.size();
  end

endmodule

[dv/set_assoc_lru_cache_lookup_tb.sv]
// Top of the cache lookup testbench: clock, reset, stimulus and verdict.
// Depends on salc_pkg, salc_in_if, salc_out_if, salc_lookup_checker and the block.
module set_assoc_lru_cache_lookup_tb;
  import salc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_LINE_BITS;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  int                   fail_count, pending;
  int                   words_sent = 0;

  // Address pools: a few tags share a few low parts, so that every config lands
  // many references on the same sets and the sets fill, hit and evict.
  bit [27:0] tag_pool [6];
  bit [19:0] low_pool [3];

  salc_in_if  in_ch();
  salc_out_if out_ch();

  set_assoc_lru_cache_lookup uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  salc_lookup_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random back-pressure, one long hold-off so the input queue fills
  // and the input stalls, and one stretch where the receiver is always ready.
  initial begin
    int cyc;
    cyc = 0;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= 5200 && cyc < 5300) out_ch.ready <= 0;
      else if (cyc >= 7000 && cyc < 7400) out_ch.ready <= 1;
      else out_ch.ready <= ($urandom_range(0, 99) >= 31);
    end
  end

  // Offers one reference word and returns at the falling edge after it is taken.
  // Valid stays high into the next word unless an idle gap is drawn.
  task automatic send_ref(input bit [ADDRESS_BITS-1:0] addr, input bit wr);
    bool_gap: begin
      if ((words_sent < 400 || words_sent > 560) && $urandom_range(0, 99) < 31) begin
        in_ch.valid <= 0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
    end
    in_ch.valid <= 1;
    in_ch.address <= addr;
    in_ch.is_write <= wr;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    words_sent++;
  endtask

  // Drains the block, then writes all three registers. The block is idle once
  // the last expected word has arrived, since every reference makes a result.
  task automatic set_config(input bit [3:0] lb, input bit [3:0] sb, input bit [3:0] wc);
    in_ch.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= CFG_LINE_BITS;
    cfg_data <= lb;
    @(negedge clk);
    cfg_index <= CFG_SET_BITS;
    cfg_data <= sb;
    @(negedge clk);
    cfg_index <= CFG_WAY_COUNT;
    cfg_data <= wc;
    @(negedge clk);
    cfg_we <= 0;
    for (int i = 0; i < 6; i++) tag_pool[i] = 28'($urandom);
    for (int i = 0; i < 3; i++) low_pool[i] = 20'($urandom);
  endtask

  // Mostly pooled addresses for reuse, the rest fully random for bit coverage.
  task automatic send_random(input int count);
    bit [ADDRESS_BITS-1:0] addr;
    repeat (count) begin
      if ($urandom_range(0, 99) < 75)
        addr = {tag_pool[$urandom_range(0, 5)], low_pool[$urandom_range(0, 2)] ^ 20'($urandom_range(0, 3))};
      else
        addr = {16'($urandom), 32'($urandom)};
      send_ref(addr, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.address = '0;
    in_ch.is_write = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Reset config: cold miss, write hit, all-ones address, then five lines on set 0
    // so the four ways fill and the dirty line at address zero is evicted.
    send_ref('0, 0);
    send_ref('0, 1);
    send_ref('1, 1);
    send_ref('1, 0);
    for (int k = 1; k <= 5; k++) send_ref(ADDRESS_BITS'(k) << 18, k[0]);
    send_ref('0, 0);
    send_ref(ADDRESS_BITS'(3) << 18, 0);

    // One set, one way, smallest line: every new line evicts, writes leave it dirty.
    set_config(4'd2, 4'd0, 4'd1);
    for (int k = 0; k < 6; k++) send_ref(ADDRESS_BITS'(k) << 2, 1);
    send_ref('1, 0);
    send_ref(ADDRESS_BITS'(5) << 2, 0);

    // Random phases over extremes, out-of-range values and middle settings.
    set_config(4'd8, 4'd12, 4'd4);
    send_random(175);
    set_config(4'd0, 4'd15, 4'd0);
    send_random(175);
    set_config(4'd15, 4'd13, 4'd7);
    send_random(175);
    set_config(4'd4, 4'd3, 4'd2);
    send_random(175);
    set_config(4'd3, 4'd1, 4'd3);
    send_random(175);
    set_config(4'd6, 4'd12, 4'd12);
    send_random(175);

    in_ch.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
